// ----- rtl/core/rcs_pkg.sv -----
// Shared types, constants and helper functions of the radix conversion stream block.
package rcs_pkg;

	// Default width of the accumulated value.
	localparam int VALUE_BITS_DEFAULT = 32;

	// Quotient bits resolved per cycle by the digit divider.
	localparam int DIV_STEPS = 4;

	// Digit store depth and address width.
	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = 6;

	// Register widths and reset values.
	localparam int BASE_W = 6;
	localparam logic [BASE_W-1:0] INPUT_BASE_RESET  = 6'd10;
	localparam logic [BASE_W-1:0] OUTPUT_BASE_RESET = 6'd16;
	localparam logic [BASE_W-1:0] OUTPUT_BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] OUTPUT_BASE_MAX   = 6'd36;

	// Configuration register indexes.
	localparam logic CFG_INPUT_BASE  = 1'b0;
	localparam logic CFG_OUTPUT_BASE = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// ASCII anchors for digit decoding and encoding.
	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_NINE   = 8'h39;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [7:0] UPPER_GAP = 8'd7;
	localparam logic [7:0] LOWER_GAP = 8'd39;

	// Input item.
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [7:0] digit_code;
		logic       last_digit;
		logic [1:0] status;
	} out_item_t;

	// Decoded digit character.
	typedef struct packed {
		logic              valid;
		logic [BASE_W-1:0] value;
	} digit_val_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic mac;
		logic div_step;
		logic mem_rd;
		logic emit_digit;
		logic emit_err;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_char;
		logic err_next;
		logic div_done;
		logic slot_free;
		logic ptr_zero;
	} dp_stat_t;

	// Maps an ASCII character to its digit value; non-digits are flagged invalid.
	function automatic digit_val_t char_value(input logic [7:0] c);
		digit_val_t r;
		logic [7:0] t;
		r.valid = 1'b1;
		t       = 8'd0;
		if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
			t = c - ASCII_ZERO;
		end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			t = c - ASCII_ZERO - UPPER_GAP;
		end else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
			t = c - ASCII_ZERO - LOWER_GAP;
		end else begin
			r.valid = 1'b0;
		end
		r.value = t[BASE_W-1:0];
		return r;
	endfunction

	// Maps a digit value to ASCII with lowercase letters above nine.
	function automatic logic [7:0] digit_ascii(input logic [BASE_W-1:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd10) begin
			return ASCII_ZERO + w;
		end
		return ASCII_ZERO + w + LOWER_GAP;
	endfunction

	// Limits the output base to the supported range.
	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		if (b < OUTPUT_BASE_MIN) begin
			return OUTPUT_BASE_MIN;
		end
		if (b > OUTPUT_BASE_MAX) begin
			return OUTPUT_BASE_MAX;
		end
		return b;
	endfunction

endpackage

// ----- rtl/core/rcs_ctrl.sv -----
// Controller state machine of the radix conversion stream block.
module rcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rcs_pkg::dp_stat_t  stat,
	output rcs_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MAC  = 6'b000010,
		S_ERR  = 6'b000100,
		S_DIV  = 6'b001000,
		S_RD   = 6'b010000,
		S_LD   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state selection.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_MAC;
				end
			end
			S_MAC: begin
				if (!stat.last_char) begin
					state_d = S_IDLE;
				end else if (stat.err_next) begin
					state_d = S_ERR;
				end else begin
					state_d = S_DIV;
				end
			end
			S_ERR: begin
				if (stat.slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_LD;
			end
			S_LD: begin
				if (stat.slot_free) begin
					state_d = stat.ptr_zero ? S_IDLE : S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands decoded from the current state.
	assign in_ready       = (state_q == S_IDLE);
	assign cmd.latch_in   = (state_q == S_IDLE) && in_valid;
	assign cmd.mac        = (state_q == S_MAC);
	assign cmd.div_step   = (state_q == S_DIV);
	assign cmd.mem_rd     = (state_q == S_RD);
	assign cmd.emit_digit = (state_q == S_LD) && stat.slot_free;
	assign cmd.emit_err   = (state_q == S_ERR) && stat.slot_free;

endmodule

// ----- rtl/core/rcs_dp.sv -----
// Datapath of the radix conversion stream block: accumulator, digit divider and digit store.
module rcs_dp #(
	parameter int VALUE_BITS = rcs_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [rcs_pkg::BASE_W-1:0] cfg_data,
	input  rcs_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rcs_pkg::out_item_t        out_data,
	input  rcs_pkg::ctrl_cmd_t        cmd,
	output rcs_pkg::dp_stat_t         stat
);

	localparam int BW     = rcs_pkg::BASE_W;
	localparam int AW     = rcs_pkg::STORE_AW;
	localparam int PW     = VALUE_BITS + BW;
	localparam int DIV_W  = ((VALUE_BITS + rcs_pkg::DIV_STEPS - 1) / rcs_pkg::DIV_STEPS)
		* rcs_pkg::DIV_STEPS;
	localparam int NSTEP  = DIV_W / rcs_pkg::DIV_STEPS;
	localparam int SW     = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam int CNT_W  = AW + 1;

	// Configuration registers.
	logic [BW-1:0] in_base_q;
	logic [BW-1:0] out_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_base_q  <= rcs_pkg::INPUT_BASE_RESET;
			out_base_q <= rcs_pkg::OUTPUT_BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rcs_pkg::CFG_INPUT_BASE:  in_base_q  <= cfg_data;
				rcs_pkg::CFG_OUTPUT_BASE: out_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latched input character.
	logic [7:0] char_q;
	logic       last_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			char_q <= in_data.char_code;
			last_q <= in_data.last_char;
		end
	end

	// Multiply-add with overflow and digit validity checks.
	logic [VALUE_BITS-1:0] acc_q;
	logic [1:0]            flags_q;
	rcs_pkg::digit_val_t   dv;
	logic [PW-1:0]         prod;
	logic                  ovf;
	logic                  inv;
	logic [1:0]            flags_next;
	logic [VALUE_BITS-1:0] acc_next;

	always_comb begin
		dv         = rcs_pkg::char_value(char_q);
		prod       = PW'(acc_q) * PW'(in_base_q) + PW'(dv.value);
		ovf        = |prod[PW-1:VALUE_BITS];
		inv        = !dv.valid || (dv.value >= in_base_q);
		flags_next = flags_q;
		acc_next   = acc_q;
		if (inv) begin
			flags_next[0] = 1'b1;
		end else if (flags_q == 2'b00) begin
			if (ovf) begin
				flags_next[1] = 1'b1;
			end else begin
				acc_next = prod[VALUE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			flags_q <= 2'b00;
		end else if (cmd.mac) begin
			if (last_q) begin
				acc_q   <= '0;
				flags_q <= 2'b00;
			end else begin
				acc_q   <= acc_next;
				flags_q <= flags_next;
			end
		end
	end

	// Error code captured on every multiply-add step, used when a number ends in error.
	logic [1:0] err_code_q;

	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			err_code_q <= flags_next[0] ? rcs_pkg::ST_INVALID : rcs_pkg::ST_OVERFLOW;
		end
	end

	// Digit divider: restoring division, several quotient bits per cycle.
	logic [DIV_W-1:0] quo_q;
	logic [BW-1:0]    rem_q;
	logic [BW-1:0]    dbase_q;
	logic [SW-1:0]    step_q;
	logic [CNT_W-1:0] count_q;
	logic [DIV_W-1:0] quo_d;
	logic [BW-1:0]    rem_d;
	logic [BW:0]      r7;
	logic             last_step;
	logic             div_fin;

	always_comb begin
		quo_d = quo_q;
		rem_d = rem_q;
		r7    = '0;
		for (int i = 0; i < rcs_pkg::DIV_STEPS; i++) begin
			r7    = {rem_d, quo_d[DIV_W-1]};
			quo_d = {quo_d[DIV_W-2:0], 1'b0};
			if (r7 >= {1'b0, dbase_q}) begin
				r7       = r7 - {1'b0, dbase_q};
				quo_d[0] = 1'b1;
			end
			rem_d = r7[BW-1:0];
		end
	end

	assign last_step = (step_q == SW'(NSTEP - 1));
	assign div_fin   = last_step && ((quo_d == '0) || (count_q == CNT_W'(rcs_pkg::STORE_DEPTH - 1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			count_q <= '0;
		end else if (cmd.mac) begin
			step_q  <= '0;
			count_q <= '0;
		end else if (cmd.div_step) begin
			if (last_step) begin
				step_q  <= '0;
				count_q <= count_q + 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			quo_q   <= DIV_W'(acc_next);
			rem_q   <= '0;
			dbase_q <= rcs_pkg::clamp_base(out_base_q);
		end else if (cmd.div_step) begin
			quo_q <= quo_d;
			rem_q <= last_step ? '0 : rem_d;
		end
	end

	// Digit store, least significant digit first.
	logic [BW-1:0] digit_mem [rcs_pkg::STORE_DEPTH];
	logic [BW-1:0] rd_data_q;
	logic [AW-1:0] ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.div_step && last_step) begin
			digit_mem[count_q[AW-1:0]] <= rem_d;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= digit_mem[ptr_q];
		end
	end

	// Read pointer walks from the most significant digit down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.div_step && div_fin) begin
			ptr_q <= count_q[AW-1:0];
		end else if (cmd.emit_digit && (ptr_q != '0)) begin
			ptr_q <= ptr_q - 1'b1;
		end
	end

	// Output register; a new result loads once the previous one is transferred.
	logic               out_valid_q;
	rcs_pkg::out_item_t out_q;
	logic               slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_digit || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_digit) begin
			out_q.digit_code <= rcs_pkg::digit_ascii(rd_data_q);
			out_q.last_digit <= (ptr_q == '0);
			out_q.status     <= rcs_pkg::ST_OK;
		end else if (cmd.emit_err) begin
			out_q.digit_code <= 8'd0;
			out_q.last_digit <= 1'b1;
			out_q.status     <= err_code_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status toward the controller.
	assign stat.last_char = last_q;
	assign stat.err_next  = (flags_next != 2'b00);
	assign stat.div_done  = div_fin;
	assign stat.slot_free = slot_free;
	assign stat.ptr_zero  = (ptr_q == '0);

endmodule

// ----- rtl/core/radix_conversion_stream_top.sv -----
// A character that is not last takes the controller from S_IDLE through S_MAC back to
// S_IDLE. The last character holds it in S_DIV while the divider forms the output digits;
// each is then read in S_RD and emitted from S_LD, and an error result from S_ERR, once
// the slot is free. The divider's 4 quotient bits per cycle set the conversion time.
// Reset (arst_n low, asynchronous) clears control state, the value, the flags and the
// bases to 10 and 16; the digit store is not cleared and needs no clearing pass.
module radix_conversion_stream_top #(
	parameter int VALUE_BITS = rcs_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rcs_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rcs_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [rcs_pkg::BASE_W-1:0] cfg_data
);

	rcs_pkg::ctrl_cmd_t cmd;
	rcs_pkg::dp_stat_t  stat;

	// Sequencer.
	rcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic, storage and output register.
	rcs_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
